/* rtl/afu_pkg.sv */
// Shared types, constants and the sigmoid point table of the activation function unit.
`timescale 1ns / 1ps

package afu_pkg;

	// Fixed-point format of the data path (signed Q4.12)
	localparam int DATA_W = 16;
	localparam int Q_FRAC = 12;

	// Sigmoid table: SIG_SEGMENTS segments over the clamped range [-2.0, +2.0]
	localparam int SEG_W        = 5;
	localparam int SIG_SEGMENTS = 1 << SEG_W;
	localparam int IDX_W        = SEG_W + 1;
	localparam int X_SPAN_W     = 14;
	localparam int U_W          = X_SPAN_W + 1;
	localparam int FRAC_W       = X_SPAN_W - SEG_W;
	localparam int S_W          = Q_FRAC + 1;

	localparam logic signed [DATA_W-1:0] X_LO = -16'sd8192;
	localparam logic signed [DATA_W-1:0] X_HI = 16'sd8192;
	localparam logic signed [DATA_W:0]   X_OFFSET = 17'sd8192;

	localparam logic [S_W-1:0]    S_ONE  = 13'd4096;
	localparam logic [DATA_W-1:0] Q_ONE  = 16'd4096;
	localparam logic [DATA_W-1:0] Q_HALF = 16'd2048;

	// Points of 1/(1+exp(-5x)) at x = -2 + k/8, rounded to Q4.12
	localparam logic [S_W-1:0] SIG_TABLE [0:SIG_SEGMENTS] = '{
		13'd0,    13'd0,    13'd1,    13'd1,    13'd2,    13'd4,    13'd8,    13'd15,
		13'd27,   13'd51,   13'd94,   13'd172,  13'd311,  13'd545,  13'd912,  13'd1428,
		13'd2048,
		13'd2668, 13'd3184, 13'd3551, 13'd3785, 13'd3924, 13'd4002, 13'd4045, 13'd4069,
		13'd4081, 13'd4088, 13'd4092, 13'd4094, 13'd4095, 13'd4095, 13'd4096, 13'd4096
	};

	// Function codes; the remaining codes pass the value through
	typedef enum logic [2:0] {
		FUNC_SIGMOID    = 3'd0,
		FUNC_RELU       = 3'd1,
		FUNC_SIG_DERIV  = 3'd2,
		FUNC_RELU_DERIV = 3'd3,
		FUNC_PASS       = 3'd4
	} func_t;

	// Load enables of the interpolation stages
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} stage_en_t;

endpackage

/* rtl/activation_function_unit.sv */
// Top level of the activation function unit: four-stage pipeline with valid/ready channels.
`timescale 1ns / 1ps

// Elementwise activation on signed Q4.12 data. Each transaction carries a function
// code and one value and yields exactly one result: 0 sigmoid 1/(1+exp(-5a)),
// 1 ReLU, 2 sigmoid derivative s(1-s), 3 ReLU derivative (0.5 at zero), and any
// other code returns the value unchanged. The sigmoid interpolates linearly
// between 33 table points over [-2.0, +2.0]; inputs outside that range are
// clamped. A transaction moves through the four stages into the output register,
// and a new one is taken every cycle while input ready is high. Each stage has its
// own valid bit and moves forward when the next stage is empty or moving, so a
// stall on the output fills the bubbles ahead of it before input ready drops.

module activation_function_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          func,
	input  logic signed [afu_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [afu_pkg::DATA_W-1:0]   result
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [2:0]                          func_s1, func_s2, func_s3;
	logic signed [afu_pkg::DATA_W-1:0]   value_s1;
	logic [afu_pkg::IDX_W-1:0]           idx_s1;
	logic [afu_pkg::FRAC_W-1:0]          frac_s1;
	logic signed [afu_pkg::DATA_W-1:0]   simple_s2, simple_s3;
	logic signed [afu_pkg::DATA_W-1:0]   result_s4;
	logic [afu_pkg::S_W-1:0]             sig_s3;

	logic signed [afu_pkg::DATA_W:0]     shifted;
	logic [afu_pkg::U_W-1:0]             u_pos;
	logic signed [afu_pkg::DATA_W-1:0]   simple_val;
	logic [2*afu_pkg::S_W-1:0]           dprod;
	logic signed [afu_pkg::DATA_W-1:0]   deriv;
	logic signed [afu_pkg::DATA_W-1:0]   result_next;
	afu_pkg::stage_en_t                  stage_en;

	// Per-stage flow control
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: clamp to [-2.0, +2.0] and split into segment and fraction
	assign shifted = (value < afu_pkg::X_LO) ? '0
		: (value > afu_pkg::X_HI) ? (afu_pkg::X_OFFSET <<< 1)
		: ((afu_pkg::DATA_W+1)'(value) + afu_pkg::X_OFFSET);
	assign u_pos = shifted[afu_pkg::U_W-1:0];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			func_s1  <= func;
			value_s1 <= value;
			idx_s1   <= u_pos[afu_pkg::U_W-1:afu_pkg::FRAC_W];
			frac_s1  <= u_pos[afu_pkg::FRAC_W-1:0];
		end
	end

	// Stage 2: results that need no table
	always_comb begin
		case (func_s1)
			afu_pkg::FUNC_RELU:
				simple_val = (value_s1 > 0) ? value_s1 : '0;
			afu_pkg::FUNC_RELU_DERIV:
				simple_val = (value_s1 > 0) ? afu_pkg::Q_ONE
					: (value_s1 < 0) ? '0 : afu_pkg::Q_HALF;
			default:
				simple_val = value_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			func_s2   <= func_s1;
			simple_s2 <= simple_val;
		end
		if (rdy3) begin
			func_s3   <= func_s2;
			simple_s3 <= simple_s2;
		end
	end

	// Stages 2 and 3: sigmoid interpolation
	assign stage_en.en_s2 = rdy2;
	assign stage_en.en_s3 = rdy3;

	afu_sig_interp u_interp (
		.clk      (clk),
		.stage_en (stage_en),
		.idx_s1   (idx_s1),
		.frac_s1  (frac_s1),
		.sig_s3   (sig_s3)
	);

	// Stage 4: derivative s(1-s) and final selection
	assign dprod = (2*afu_pkg::S_W)'(sig_s3) * (2*afu_pkg::S_W)'(afu_pkg::S_ONE - sig_s3)
		+ (2*afu_pkg::S_W)'(afu_pkg::Q_HALF);
	assign deriv = afu_pkg::DATA_W'(dprod[2*afu_pkg::S_W-1:afu_pkg::Q_FRAC]);

	always_comb begin
		case (func_s3)
			afu_pkg::FUNC_SIGMOID:   result_next = afu_pkg::DATA_W'(sig_s3);
			afu_pkg::FUNC_SIG_DERIV: result_next = deriv;
			default:                 result_next = simple_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			result_s4 <= result_next;
		end
	end

	assign out_valid = v_s4;
	assign result    = result_s4;

	// Interpolated sigmoid never exceeds 1.0
	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (func_s3 == afu_pkg::FUNC_SIGMOID || func_s3 == afu_pkg::FUNC_SIG_DERIV)
		|-> sig_s3 <= afu_pkg::S_ONE)
		else $error("sigmoid above 1.0");

	// ReLU derivative is 0, 0.5 or 1.0
	a_relu_deriv: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (func_s3 == afu_pkg::FUNC_RELU_DERIV)
		|-> (simple_s3 == 0 || simple_s3 == 16'sd2048 || simple_s3 == 16'sd4096))
		else $error("bad ReLU derivative");

	// A stalled middle stage keeps its transaction
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2 && $stable(func_s2) && $stable(simple_s2))
		else $error("stage 2 lost a transaction under stall");

	// Accepted input lands in stage 1
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction missing from stage 1");

endmodule

/* rtl/afu_sig_interp.sv */
// Two-stage sigmoid interpolation: table lookup, then slope multiply and add.
`timescale 1ns / 1ps

module afu_sig_interp (
	input  logic                         clk,
	input  afu_pkg::stage_en_t           stage_en,
	input  logic [afu_pkg::IDX_W-1:0]    idx_s1,
	input  logic [afu_pkg::FRAC_W-1:0]   frac_s1,
	output logic [afu_pkg::S_W-1:0]      sig_s3
);

	localparam int PROD_W = afu_pkg::S_W + afu_pkg::FRAC_W + 1;
	localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (afu_pkg::FRAC_W - 1);

	logic [afu_pkg::IDX_W-1:0]  next_idx;
	logic [afu_pkg::S_W-1:0]    base_pt;
	logic [afu_pkg::S_W-1:0]    next_pt;
	logic [afu_pkg::S_W-1:0]    base_s2;
	logic [afu_pkg::S_W-1:0]    diff_s2;
	logic [afu_pkg::FRAC_W-1:0] frac_s2;
	logic [PROD_W-1:0]          prod;
	logic [afu_pkg::S_W-1:0]    step;

	// Neighboring points; the last point is its own neighbor (fraction is zero there)
	assign next_idx = (idx_s1 == afu_pkg::IDX_W'(afu_pkg::SIG_SEGMENTS)) ? idx_s1
		: idx_s1 + afu_pkg::IDX_W'(1);
	assign base_pt  = afu_pkg::SIG_TABLE[idx_s1];
	assign next_pt  = afu_pkg::SIG_TABLE[next_idx];

	always_ff @(posedge clk) begin
		if (stage_en.en_s2) begin
			base_s2 <= base_pt;
			diff_s2 <= next_pt - base_pt;
			frac_s2 <= frac_s1;
		end
	end

	// Table is monotonic, so the slope is never negative: round half up
	assign prod = PROD_W'(diff_s2) * PROD_W'(frac_s2) + ROUND;
	assign step = prod[afu_pkg::FRAC_W +: afu_pkg::S_W];

	always_ff @(posedge clk) begin
		if (stage_en.en_s3) begin
			sig_s3 <= base_s2 + step;
		end
	end

endmodule

/* bench/tb.sv */
// Self-checking testbench of the activation function unit with an independent predictor.
`timescale 1ns / 1ps

module tb;

	localparam int DATA_W     = afu_pkg::DATA_W;
	localparam int SEGS       = afu_pkg::SIG_SEGMENTS;
	localparam int X_HALF     = 8192;
	localparam int X_FULL     = 16384;
	localparam int HOLD_LEN   = 80;
	localparam int STALL_MAX  = 2000;
	localparam int DRAIN_WAIT = 8;
	localparam longint unsigned Q31_ONE = 64'h8000_0000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [2:0]               func = afu_pkg::FUNC_SIGMOID;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] result;

	// Sigmoid points, expected results in order, bookkeeping
	int                       sig_points [0:SEGS];
	logic signed [DATA_W-1:0] pending_results [$];
	int                       error_count = 0;
	int                       idle_cycles = 0;
	bit                       quiet = 1'b0;
	bit                       hold_request = 1'b0;

	activation_function_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result   (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Point k of 1/(1+exp(-5x)) at x = -2 + 4k/SEGS, Q4.12, via truncated Taylor series
	function automatic int sigmoid_point(int k);
		longint          num;
		bit              neg;
		longint unsigned mag, y, term, r, den, s;
		longint          sum;
		num  = longint'(X_FULL) * k - longint'(X_HALF) * SEGS;
		neg  = num < 0;
		mag  = neg ? -num : num;
		y    = ((mag * 5) << 15) / SEGS;
		term = Q31_ONE;
		sum  = Q31_ONE;
		for (int n = 1; n <= 16; n++) begin
			term = ((term * y) >> 31) / n;
			if (n % 2)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(Q31_ONE))
			sum = Q31_ONE;
		r = sum;
		// exp(-5|x|) = exp(-y)^16
		for (int n = 0; n < 4; n++)
			r = (r * r + (64'd1 << 30)) >> 31;
		den = Q31_ONE + r;
		if (!neg)
			s = ((64'd1 << 43) + den / 2) / den;
		else
			s = ((r << 12) + den / 2) / den;
		return int'(s);
	endfunction

	// Interpolated sigmoid over the clamped input
	function automatic int sigmoid_of(int a);
		int     p, i, f;
		longint diff, step;
		if (a < -X_HALF)
			a = -X_HALF;
		if (a > X_HALF)
			a = X_HALF;
		p = (a + X_HALF) * SEGS;
		i = p / X_FULL;
		f = p % X_FULL;
		if (i >= SEGS)
			return sig_points[SEGS];
		diff = sig_points[i+1] - sig_points[i];
		step = (diff * f + X_HALF) / X_FULL;
		return sig_points[i] + int'(step);
	endfunction

	function automatic logic signed [DATA_W-1:0] activation_of(logic [2:0] f,
			logic signed [DATA_W-1:0] v);
		int a, s, res;
		a = v;
		case (f)
			afu_pkg::FUNC_SIGMOID: res = sigmoid_of(a);
			afu_pkg::FUNC_RELU: res = (a > 0) ? a : 0;
			afu_pkg::FUNC_SIG_DERIV: begin
				s = sigmoid_of(a);
				res = (s * (4096 - s) + 2048) >>> 12;
			end
			afu_pkg::FUNC_RELU_DERIV: res = (a > 0) ? 4096 : ((a < 0) ? 0 : 2048);
			default: res = a;
		endcase
		return res[DATA_W-1:0];
	endfunction

	// Mostly short gaps, a few long ones, none in quiet stretches
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Send one transaction after a gap and record its expected result
	task automatic send_item(input logic [2:0] f, input logic signed [DATA_W-1:0] v,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(activation_of(f, v));
	endtask

	// Receiver: random stalls, quiet stretches, and a long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_request = 1'b0;
			end else if (quiet) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		logic signed [DATA_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: result %0d", result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result !== want) begin
					$error("result mismatch: expected %0d, actual %0d", want, result);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_MAX) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Field extremes, clamp edges, zero handling and every function code
	task automatic test_directed();
		send_item(afu_pkg::FUNC_SIGMOID, -16'sd32768, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, -16'sd8193, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, -16'sd8192, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, -16'sd3000, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, -16'sd1, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, 16'sd0, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, 16'sd1, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, 16'sd4352, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, 16'sd8191, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, 16'sd8192, pick_gap());
		send_item(afu_pkg::FUNC_SIGMOID, 16'sd32767, pick_gap());
		send_item(afu_pkg::FUNC_RELU, -16'sd32768, pick_gap());
		send_item(afu_pkg::FUNC_RELU, 16'sd0, pick_gap());
		send_item(afu_pkg::FUNC_RELU, 16'sd1, pick_gap());
		send_item(afu_pkg::FUNC_RELU, 16'sd32767, pick_gap());
		send_item(afu_pkg::FUNC_SIG_DERIV, 16'sd0, pick_gap());
		send_item(afu_pkg::FUNC_SIG_DERIV, -16'sd8192, pick_gap());
		send_item(afu_pkg::FUNC_SIG_DERIV, 16'sd5000, pick_gap());
		send_item(afu_pkg::FUNC_RELU_DERIV, -16'sd1, pick_gap());
		send_item(afu_pkg::FUNC_RELU_DERIV, 16'sd0, pick_gap());
		send_item(afu_pkg::FUNC_RELU_DERIV, 16'sd1, pick_gap());
		// pass-through and the unnamed codes above it
		send_item(afu_pkg::FUNC_PASS, 16'sd32767, pick_gap());
		send_item(3'd5, -16'sd32768, pick_gap());
		send_item(3'd6, 16'sh5555, pick_gap());
		send_item(3'd7, 16'sh2aaa, pick_gap());
	endtask

	// Output held off for a long stretch while input keeps coming
	task automatic test_backpressure();
		hold_request = 1'b1;
		for (int n = 0; n < 30; n++)
			send_item(3'($urandom_range(4)), 16'($urandom), 0);
	endtask

	// Random mix weighted toward the sigmoid range, with quiet stretches
	task automatic test_random();
		logic [2:0]               f;
		logic signed [DATA_W-1:0] v;
		int                       r;
		for (int n = 0; n < 350; n++) begin
			quiet = ((n / 50) % 4) == 3;
			f = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
			r = $urandom_range(99);
			if (r < 45)
				v = 16'($signed($urandom_range(18000)) - 9000);
			else if (r < 60)
				v = 16'($signed($urandom_range(32)) - 16);
			else if (r < 70)
				v = 16'(-X_HALF + 512 * $signed($urandom_range(32)));
			else
				v = 16'($urandom);
			send_item(f, v, pick_gap());
		end
		quiet = 1'b0;
	endtask

	initial begin
		for (int k = 0; k <= SEGS; k++)
			sig_points[k] = sigmoid_point(k);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;

		// drain, then let the pipeline settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
